// File: rtl/lcdseq_pkg.sv
`default_nettype none
package lcdseq_pkg;

	// request codes on the cmd field
	localparam logic [2:0] CMD_INSTR   = 3'd0;
	localparam logic [2:0] CMD_CHAR_W  = 3'd1;
	localparam logic [2:0] CMD_CHAR_R  = 3'd2;
	localparam logic [2:0] CMD_GET_POS = 3'd3;
	localparam logic [2:0] CMD_SET_POS = 3'd4;
	localparam logic [2:0] CMD_INIT    = 3'd5;
	localparam logic [2:0] CMD_NIBBLE  = 3'd6;
	localparam logic [2:0] CMD_RSVD    = 3'd7;

	// result kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	localparam int unsigned INIT_LEN  = 9;
	localparam int unsigned BURST_MAX = 3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POLL_HI,
		PH_POLL_LO,
		PH_RD_HI,
		PH_RD_LO
	} phase_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] byte_value;
		logic [5:0] pos_x;
		logic [1:0] pos_y;
		logic [3:0] bus_nibble;
	} req_t;

	typedef struct packed {
		logic [1:0] bus_kind;
		logic       rs;
		logic [3:0] nibble;
		logic [7:0] reply_byte;
		logic [5:0] reply_x;
		logic       reply_y;
		logic       rejected;
		logic       last;
	} result_t;

	typedef struct packed {
		result_t [BURST_MAX-1:0] res;
		logic [1:0]              cnt;
	} burst_t;

	function automatic logic [7:0] init_byte(input logic [3:0] step);
		logic [7:0] b;
		case (step)
			4'd0, 4'd1, 4'd2: b = 8'h03;
			4'd3: b = 8'h02;
			4'd4: b = 8'h28;
			4'd5: b = 8'h0C;
			4'd6: b = 8'h06;
			4'd7: b = 8'h01;
			4'd8: b = 8'h80;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic result_t mk_result(input logic [1:0] kind, input logic rs,
		input logic [3:0] nib, input logic [7:0] rb, input logic [5:0] rx,
		input logic ry, input logic rej, input logic fin);
		result_t r;
		r.bus_kind   = kind;
		r.rs         = rs;
		r.nibble     = nib;
		r.reply_byte = rb;
		r.reply_x    = rx;
		r.reply_y    = ry;
		r.rejected   = rej;
		r.last       = fin;
		return r;
	endfunction

	// one result only, always final
	function automatic burst_t single(input result_t r);
		burst_t bu;
		bu        = '0;
		bu.res[0] = r;
		bu.cnt    = 2'd1;
		return bu;
	endfunction

	// byte write: high nibble, low nibble, first busy poll strobe
	function automatic burst_t write_burst(input logic [7:0] b, input logic rs);
		burst_t bu;
		bu.res[0] = mk_result(KIND_WRITE, rs, b[7:4], 8'h00, 6'd0, 1'b0, 1'b0, 1'b0);
		bu.res[1] = mk_result(KIND_WRITE, rs, b[3:0], 8'h00, 6'd0, 1'b0, 1'b0, 1'b0);
		bu.res[2] = mk_result(KIND_READ, 1'b0, 4'h0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1);
		bu.cnt    = 2'd3;
		return bu;
	endfunction

endpackage
`default_nettype wire

// File: rtl/lcdseq_req_if.sv
`default_nettype none
interface lcdseq_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] byte_value;
	logic [5:0] pos_x;
	logic [1:0] pos_y;
	logic [3:0] bus_nibble;

	modport source (output valid, cmd, byte_value, pos_x, pos_y, bus_nibble,
		input ready);
	modport sink (input valid, cmd, byte_value, pos_x, pos_y, bus_nibble,
		output ready);
endinterface
`default_nettype wire

// File: rtl/lcdseq_rsp_if.sv
`default_nettype none
interface lcdseq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] bus_kind;
	logic       rs;
	logic [3:0] nibble;
	logic [7:0] reply_byte;
	logic [5:0] reply_x;
	logic       reply_y;
	logic       rejected;
	logic       last;

	modport source (output valid, bus_kind, rs, nibble, reply_byte, reply_x, reply_y,
		rejected, last, input ready);
	modport sink (input valid, bus_kind, rs, nibble, reply_byte, reply_x, reply_y,
		rejected, last, output ready);
endinterface
`default_nettype wire

// File: rtl/char_lcd_4bit_bus_sequencer_core.sv
`default_nettype none
// Channel  Role    Item
// req      sink    host request or returned bus nibble (cmd, byte_value, pos_x,
//                  pos_y, bus_nibble)
// rsp      source  one bus event or host reply (bus_kind, rs, nibble, reply_byte,
//                  reply_x, reply_y, rejected, last)
//
// A request waits in the input register, then its 0 to 3 results are loaded into
// the burst register and leave one per cycle while rsp is ready; the burst
// register's drain sets the pace. A waiting request is loaded, and a new one
// taken, when the burst register is empty or in the cycle its last result transfers.
// Reset clears the sequencer to idle and empties both registers.
module char_lcd_4bit_bus_sequencer_core #(
	parameter int unsigned COLUMNS = 40
) (
	input  wire          clk,
	input  wire          arst_n,
	lcdseq_req_if.sink   req,
	lcdseq_rsp_if.source rsp
);

	lcdseq_pkg::req_t   item_s1;
	logic               valid_s1;
	lcdseq_pkg::burst_t burst;
	logic               load_ok;
	logic               adv;

	assign adv       = valid_s1 && load_ok;
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.valid && req.ready)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd        <= req.cmd;
			item_s1.byte_value <= req.byte_value;
			item_s1.pos_x      <= req.pos_x;
			item_s1.pos_y      <= req.pos_y;
			item_s1.bus_nibble <= req.bus_nibble;
		end
	end

	lcdseq_engine #(
		.COLUMNS(COLUMNS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.item  (item_s1),
		.burst (burst)
	);

	lcdseq_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv),
		.burst_in(burst),
		.load_ok (load_ok),
		.rsp     (rsp)
	);

`ifndef NO_ASSERTIONS
	a_reply_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.bus_kind == lcdseq_pkg::KIND_REPLY) |-> rsp.last)
		else $error("host reply not marked final");

	a_write_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.bus_kind == lcdseq_pkg::KIND_WRITE) |-> !rsp.last)
		else $error("write strobe ends a burst");

	a_reject_reply: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.rejected |-> (rsp.bus_kind == lcdseq_pkg::KIND_REPLY))
		else $error("rejection outside a host reply");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.last |=> !rsp.valid || $past(adv))
		else $error("results continue past the final one without a new load");
`endif

endmodule
`default_nettype wire

// File: rtl/lcdseq_engine.sv
`default_nettype none
module lcdseq_engine #(
	parameter int unsigned COLUMNS = 40
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   adv,
	input  wire lcdseq_pkg::req_t item,
	output lcdseq_pkg::burst_t    burst
);

	lcdseq_pkg::phase_t phase_q, phase_d;
	logic [2:0] op_q, op_d;
	logic [3:0] hi_q, hi_d;
	logic [3:0] step_q, step_d;

	logic       idle;
	logic       pos_bad;
	logic [7:0] rd_byte;
	logic       more_init;

	assign idle      = (phase_q == lcdseq_pkg::PH_IDLE);
	assign pos_bad   = ({1'b0, item.pos_x} >= 7'(COLUMNS)) || item.pos_y[1];
	assign rd_byte   = {hi_q, item.bus_nibble};
	assign more_init = (op_q == lcdseq_pkg::CMD_INIT) &&
		(step_q < 4'(lcdseq_pkg::INIT_LEN - 1));

	// next state
	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		hi_d    = hi_q;
		step_d  = step_q;
		if (item.cmd == lcdseq_pkg::CMD_NIBBLE) begin
			unique case (phase_q)
				lcdseq_pkg::PH_POLL_HI: begin
					hi_d    = item.bus_nibble;
					phase_d = lcdseq_pkg::PH_POLL_LO;
				end
				lcdseq_pkg::PH_RD_HI: begin
					hi_d    = item.bus_nibble;
					phase_d = lcdseq_pkg::PH_RD_LO;
				end
				lcdseq_pkg::PH_RD_LO: phase_d = lcdseq_pkg::PH_IDLE;
				lcdseq_pkg::PH_POLL_LO: begin
					if (rd_byte[7]) begin
						phase_d = lcdseq_pkg::PH_POLL_HI;
					end else if (more_init) begin
						step_d  = step_q + 4'd1;
						phase_d = lcdseq_pkg::PH_POLL_HI;
					end else begin
						phase_d = lcdseq_pkg::PH_IDLE;
					end
				end
				default: ;
			endcase
		end else if (item.cmd != lcdseq_pkg::CMD_RSVD && idle) begin
			op_d = item.cmd;
			unique case (item.cmd)
				lcdseq_pkg::CMD_CHAR_R, lcdseq_pkg::CMD_GET_POS:
					phase_d = lcdseq_pkg::PH_RD_HI;
				lcdseq_pkg::CMD_SET_POS:
					phase_d = pos_bad ? lcdseq_pkg::PH_IDLE : lcdseq_pkg::PH_POLL_HI;
				lcdseq_pkg::CMD_INIT: begin
					step_d  = 4'd0;
					phase_d = lcdseq_pkg::PH_POLL_HI;
				end
				default: phase_d = lcdseq_pkg::PH_POLL_HI;
			endcase
		end
	end

	// results for the item in the input register
	always_comb begin
		burst = '0;
		if (item.cmd == lcdseq_pkg::CMD_NIBBLE) begin
			unique case (phase_q)
				lcdseq_pkg::PH_POLL_HI, lcdseq_pkg::PH_RD_HI:
					burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(lcdseq_pkg::KIND_READ,
						(phase_q == lcdseq_pkg::PH_RD_HI) && (op_q == lcdseq_pkg::CMD_CHAR_R),
						4'h0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
				lcdseq_pkg::PH_RD_LO: begin
					if (op_q == lcdseq_pkg::CMD_CHAR_R)
						burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(
							lcdseq_pkg::KIND_REPLY, 1'b0, 4'h0, rd_byte, 6'd0, 1'b0,
							1'b0, 1'b1));
					else
						burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(
							lcdseq_pkg::KIND_REPLY, 1'b0, 4'h0, 8'h00, rd_byte[5:0],
							rd_byte[6], 1'b0, 1'b1));
				end
				lcdseq_pkg::PH_POLL_LO: begin
					if (rd_byte[7])
						burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(
							lcdseq_pkg::KIND_READ, 1'b0, 4'h0, 8'h00, 6'd0, 1'b0,
							1'b0, 1'b1));
					else if (more_init)
						burst = lcdseq_pkg::write_burst(
							lcdseq_pkg::init_byte(step_q + 4'd1), 1'b0);
					else
						burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(
							lcdseq_pkg::KIND_REPLY, 1'b0, 4'h0, 8'h00, 6'd0, 1'b0,
							1'b0, 1'b1));
				end
				default: ;
			endcase
		end else if (item.cmd != lcdseq_pkg::CMD_RSVD) begin
			if (!idle) begin
				burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(lcdseq_pkg::KIND_REPLY,
					1'b0, 4'h0, 8'h00, 6'd0, 1'b0, 1'b1, 1'b1));
			end else begin
				unique case (item.cmd)
					lcdseq_pkg::CMD_INSTR:
						burst = lcdseq_pkg::write_burst(item.byte_value, 1'b0);
					lcdseq_pkg::CMD_CHAR_W:
						burst = lcdseq_pkg::write_burst(item.byte_value, 1'b1);
					lcdseq_pkg::CMD_CHAR_R, lcdseq_pkg::CMD_GET_POS:
						burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(
							lcdseq_pkg::KIND_READ, item.cmd == lcdseq_pkg::CMD_CHAR_R,
							4'h0, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1));
					lcdseq_pkg::CMD_SET_POS: begin
						if (pos_bad)
							burst = lcdseq_pkg::single(lcdseq_pkg::mk_result(
								lcdseq_pkg::KIND_REPLY, 1'b0, 4'h0, 8'h00, 6'd0, 1'b0,
								1'b1, 1'b1));
						else
							burst = lcdseq_pkg::write_burst(
								{1'b1, item.pos_y[0], item.pos_x}, 1'b0);
					end
					default:
						burst = lcdseq_pkg::write_burst(lcdseq_pkg::init_byte(4'd0), 1'b0);
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcdseq_pkg::PH_IDLE;
			op_q    <= 3'd0;
			hi_q    <= 4'd0;
			step_q  <= 4'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			hi_q    <= hi_d;
			step_q  <= step_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/lcdseq_emitter.sv
`default_nettype none
module lcdseq_emitter (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     load,
	input  wire lcdseq_pkg::burst_t burst_in,
	output logic                    load_ok,
	lcdseq_rsp_if.source            rsp
);

	lcdseq_pkg::result_t [lcdseq_pkg::BURST_MAX-1:0] res_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	lcdseq_pkg::result_t cur;
	logic tx;
	logic done;

	always_comb begin
		case (idx_q)
			2'd0:    cur = res_q[0];
			2'd1:    cur = res_q[1];
			default: cur = res_q[2];
		endcase
	end

	assign rsp.valid      = (cnt_q != 2'd0);
	assign rsp.bus_kind   = cur.bus_kind;
	assign rsp.rs         = cur.rs;
	assign rsp.nibble     = cur.nibble;
	assign rsp.reply_byte = cur.reply_byte;
	assign rsp.reply_x    = cur.reply_x;
	assign rsp.reply_y    = cur.reply_y;
	assign rsp.rejected   = cur.rejected;
	assign rsp.last       = cur.last;

	assign tx      = rsp.valid && rsp.ready;
	assign done    = tx && (idx_q == cnt_q - 2'd1);
	assign load_ok = (cnt_q == 2'd0) || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= burst_in.cnt;
			idx_q <= 2'd0;
		end else if (done) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (tx) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= burst_in.res;
	end

endmodule
`default_nettype wire
